// ===== design/vtit_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package vtit_pkg;

  localparam int ValueW = 31;
  localparam int SlotIdxW = 12;
  localparam int CfgSizeW = 13;
  localparam logic [CfgSizeW-1:0] SizeReset = 13'd4096;

endpackage
`default_nettype wire

// ===== design/value_to_index_intern_table_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Value-to-index intern table.
// Input channel: in_valid_i / in_ready_o with value_i. Each item yields exactly one
// result on out_valid_o / out_ready_i: slot_index_o and table_full_o.
// Config channel: cfg_valid_i / cfg_ready_o with table_size_i (always ready); write
// it only while the block is idle. Values above TABLE_DEPTH act as TABLE_DEPTH.
// One item at a time. The slot table is a single-port-write RAM with a registered
// read; one compare unit checks one slot per cycle.
//   identity-slot hit or claim: identity check, then the done state
//   otherwise: scan down from the last slot until a hit or slot 0, identity slot included
//   value zero / full table: same rule; size zero: straight to the done state
// in_ready_o rises with out_valid_o, so a new item starts only once the last result is out.
// A result waits in the output register while out_ready_i is low; the next item is
// accepted then, but its own result is held until the output register frees.
// Reset: an asynchronous low on rst_ni starts a clearing pass that writes zero to
// every slot, one per cycle; in_ready_o stays low until it ends. table_size returns
// to 4096. Writing table_size does not clear the table.
module value_to_index_intern_table_unit #(
  parameter int TABLE_DEPTH = 4096
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [vtit_pkg::CfgSizeW-1:0] table_size_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [vtit_pkg::ValueW-1:0]   value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [vtit_pkg::SlotIdxW-1:0]      slot_index_o,
  output logic                               table_full_o
);

  import vtit_pkg::*;

  localparam int IdxW = $clog2(TABLE_DEPTH);
  localparam int SzW  = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StIdChk = 3'd2;
  localparam logic [2:0] StScan  = 3'd3;
  localparam logic [2:0] StDone  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [IdxW-1:0]     clr_q, clr_d;
  logic [IdxW-1:0]     k_q, k_d;
  logic [ValueW-1:0]   v_q, v_d;
  logic [IdxW-1:0]     res_idx_q, res_idx_d;
  logic                res_full_q, res_full_d;
  logic [CfgSizeW-1:0] table_size_q;
  logic                out_valid_q, out_valid_d;
  logic [SlotIdxW-1:0] slot_index_q, slot_index_d;
  logic                table_full_q, table_full_d;

  logic [SzW-1:0]      size_w;
  logic [IdxW-1:0]     last_w;
  logic                ram_we, ram_re;
  logic [IdxW-1:0]     ram_waddr, ram_raddr;
  logic [ValueW-1:0]   ram_wdata, ram_rdata;
  logic                cmp_hit;

  assign size_w = (32'(table_size_q) > 32'(TABLE_DEPTH)) ? SzW'(TABLE_DEPTH)
                                                        : SzW'(table_size_q);
  assign last_w = IdxW'(size_w - SzW'(1));

  // shared slot compare: match or empty
  assign cmp_hit = (ram_rdata == v_q) || (ram_rdata == '0);

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == StIdle);
  assign out_valid_o  = out_valid_q;
  assign slot_index_o = slot_index_q;
  assign table_full_o = table_full_q;

  vtit_slot_ram #(
    .Depth(TABLE_DEPTH),
    .AddrW(IdxW),
    .DataW(ValueW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    k_d          = k_q;
    v_d          = v_q;
    res_idx_d    = res_idx_q;
    res_full_d   = res_full_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    slot_index_d = slot_index_q;
    table_full_d = table_full_q;
    ram_we       = 1'b0;
    ram_waddr    = k_q;
    ram_wdata    = v_q;
    ram_re       = 1'b0;
    ram_raddr    = k_q;
    case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == IdxW'(TABLE_DEPTH - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          v_d = value_i;
          if (value_i != '0 && 32'(size_w) > 32'(value_i)) begin
            k_d       = value_i[IdxW-1:0];
            ram_re    = 1'b1;
            ram_raddr = value_i[IdxW-1:0];
            state_d   = StIdChk;
          end else if (size_w == '0) begin
            res_idx_d  = '0;
            res_full_d = 1'b1;
            state_d    = StDone;
          end else begin
            k_d       = last_w;
            ram_re    = 1'b1;
            ram_raddr = last_w;
            state_d   = StScan;
          end
        end
      end
      StIdChk: begin
        if (cmp_hit) begin
          ram_we     = 1'b1;
          res_idx_d  = k_q;
          res_full_d = 1'b0;
          state_d    = StDone;
        end else begin
          k_d       = last_w;
          ram_re    = 1'b1;
          ram_raddr = last_w;
          state_d   = StScan;
        end
      end
      StScan: begin
        if (cmp_hit) begin
          ram_we     = 1'b1;
          res_idx_d  = k_q;
          res_full_d = 1'b0;
          state_d    = StDone;
        end else if (k_q == '0) begin
          res_idx_d  = '0;
          res_full_d = 1'b1;
          state_d    = StDone;
        end else begin
          k_d       = k_q - 1'b1;
          ram_re    = 1'b1;
          ram_raddr = k_q - 1'b1;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          slot_index_d = SlotIdxW'(32'(res_idx_q));
          table_full_d = res_full_q;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StClear;
      clr_q        <= '0;
      out_valid_q  <= 1'b0;
      table_size_q <= SizeReset;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        table_size_q <= table_size_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q          <= k_d;
    v_q          <= v_d;
    res_idx_q    <= res_idx_d;
    res_full_q   <= res_full_d;
    slot_index_q <= slot_index_d;
    table_full_q <= table_full_d;
  end

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClear) |-> !in_ready_o)
    else $error("item accepted during clearing pass");

  a_write_only_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q != StClear) |-> (cmp_hit && (state_q == StIdChk || state_q == StScan)))
    else $error("slot written outside a hit");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != StIdle && state_q != StClear))
    else $error("sequencer idle after accepting an item");

  a_full_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && table_full_o) |-> (slot_index_o == '0))
    else $error("full result with nonzero slot index");

endmodule
`default_nettype wire

// ===== design/vtit_slot_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vtit_slot_ram #(
  parameter int Depth = 4096,
  parameter int AddrW = 12,
  parameter int DataW = 31
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire
